>>> hw/rtl/adcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcs_pkg
// Shared constants, codes and types of the ADC channel sweep capture block.
// ----------------------------------------------------------------------------
package adcs_pkg;

  // Captured channel window and field widths
  localparam int NumCh      = 12;
  localparam int FirstCh    = 8;
  localparam int SlotW      = $clog2(NumCh);
  localparam int ChW        = 5;
  localparam int CodeW      = 24;
  localparam int CountW     = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 24;

  localparam logic [ChW:0]      ChEnd    = (ChW + 1)'(FirstCh + NumCh);
  localparam logic [ChW:0]      ChStart  = (ChW + 1)'(FirstCh);
  localparam logic [SlotW:0]    NumChW   = (SlotW + 1)'(NumCh);
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Reset values of the configuration registers
  localparam logic [CodeW-1:0]  LowLimitRst  = 24'h800000;
  localparam logic [CodeW-1:0]  HighLimitRst = 24'h7FFFFF;
  localparam logic [CountW-1:0] ErrThrRst    = 8'd5;
  localparam logic [CountW-1:0] LateLimRst   = 8'd20;
  localparam logic [CountW-1:0] MaxFramesRst = 8'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLowLimit  = 3'd0,
    CfgHighLimit = 3'd1,
    CfgErrThr    = 3'd2,
    CfgLateLimit = 3'd3,
    CfgMaxFrames = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OpFrame    = 1'b0,
    OpReadBack = 1'b1
  } opcode_e;

  // Read request into the slot store (issued on input transfer)
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
  } slot_rd_req_t;

  // Write-back from the frame stage
  typedef struct packed {
    logic              store_we;
    logic              err_we;
    logic [SlotW-1:0]  addr;
    logic [CodeW-1:0]  store_data;
    logic [CountW-1:0] err_data;
  } slot_wr_req_t;

  // Read response, valid in the cycle after the request and held until the next
  typedef struct packed {
    logic [CodeW-1:0]  value;
    logic [CountW-1:0] count;
  } slot_rd_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/adcs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcs_if
// Valid/ready channels for ADC frames in and capture results out.
// ----------------------------------------------------------------------------
interface adcs_in_if
  import adcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [7:0]        status_byte;
  logic [CodeW-1:0]  sample_code;
  logic [3:0]        read_index;

  modport source (output valid, opcode, status_byte, sample_code, read_index,
                  input ready);
  modport sink   (input valid, opcode, status_byte, sample_code, read_index,
                  output ready);
endinterface

interface adcs_out_if
  import adcs_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [ChW-1:0]           channel_id;
  logic                     channel_known;
  logic                     in_range;
  logic                     error_flag;
  logic                     sweep_done;
  logic                     sweep_fail;
  logic [NumCh-1:0]         valid_mask;
  logic signed [CodeW-1:0]  read_value;
  logic [CountW-1:0]        read_error_count;

  modport source (output valid, channel_id, channel_known, in_range, error_flag,
                  sweep_done, sweep_fail, valid_mask, read_value, read_error_count,
                  input ready);
  modport sink   (input valid, channel_id, channel_known, in_range, error_flag,
                  sweep_done, sweep_fail, valid_mask, read_value, read_error_count,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/adcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/adcs_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcs_slot_store
// Per-channel code and error count memories with written bits and forwarding.
// ----------------------------------------------------------------------------
module adcs_slot_store
  import adcs_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire slot_rd_req_t rd_req_i,
  input  wire slot_wr_req_t wr_req_i,
  output slot_rd_rsp_t      rd_rsp_o
);

  logic [CodeW-1:0]  store_rdata;
  logic [CountW-1:0] err_rdata;

  logic [NumCh-1:0]  store_wr_q, err_wr_q;
  logic              store_wr_hit_q, err_wr_hit_q;
  logic [SlotW-1:0]  rd_addr_q;

  // Last write to each memory; it is always the newest value of its slot
  logic              st_fwd_vld_q, er_fwd_vld_q;
  logic [SlotW-1:0]  st_fwd_addr_q, er_fwd_addr_q;
  logic [CodeW-1:0]  st_fwd_data_q;
  logic [CountW-1:0] er_fwd_data_q;

  adcs_ram #(.Width(CodeW), .Depth(NumCh)) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (wr_req_i.store_we),
    .waddr_i (wr_req_i.addr),
    .wdata_i (wr_req_i.store_data),
    .re_i    (rd_req_i.en),
    .raddr_i (rd_req_i.addr),
    .rdata_o (store_rdata)
  );

  adcs_ram #(.Width(CountW), .Depth(NumCh)) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (wr_req_i.err_we),
    .waddr_i (wr_req_i.addr),
    .wdata_i (wr_req_i.err_data),
    .re_i    (rd_req_i.en),
    .raddr_i (rd_req_i.addr),
    .rdata_o (err_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_wr_q     <= '0;
      err_wr_q       <= '0;
      store_wr_hit_q <= 1'b0;
      err_wr_hit_q   <= 1'b0;
      st_fwd_vld_q   <= 1'b0;
      er_fwd_vld_q   <= 1'b0;
    end else begin
      if (rd_req_i.en) begin
        store_wr_hit_q <= store_wr_q[rd_req_i.addr];
        err_wr_hit_q   <= err_wr_q[rd_req_i.addr];
      end
      if (wr_req_i.store_we) begin
        store_wr_q[wr_req_i.addr] <= 1'b1;
        st_fwd_vld_q              <= 1'b1;
      end
      if (wr_req_i.err_we) begin
        err_wr_q[wr_req_i.addr] <= 1'b1;
        er_fwd_vld_q            <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_req_i.en) begin
      rd_addr_q <= rd_req_i.addr;
    end
    if (wr_req_i.store_we) begin
      st_fwd_addr_q <= wr_req_i.addr;
      st_fwd_data_q <= wr_req_i.store_data;
    end
    if (wr_req_i.err_we) begin
      er_fwd_addr_q <= wr_req_i.addr;
      er_fwd_data_q <= wr_req_i.err_data;
    end
  end

  // Forward the newest write; an entry never written reads as zero
  always_comb begin
    if (st_fwd_vld_q && st_fwd_addr_q == rd_addr_q) begin
      rd_rsp_o.value = st_fwd_data_q;
    end else if (store_wr_hit_q) begin
      rd_rsp_o.value = store_rdata;
    end else begin
      rd_rsp_o.value = '0;
    end
    if (er_fwd_vld_q && er_fwd_addr_q == rd_addr_q) begin
      rd_rsp_o.count = er_fwd_data_q;
    end else if (err_wr_hit_q) begin
      rd_rsp_o.count = err_rdata;
    end else begin
      rd_rsp_o.count = '0;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/adc_channel_sweep_capture_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_channel_sweep_capture_top
// Captures multiplexed ADC frames per channel and tracks sweep completion.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_i    | in  | valid/ready   | opcode, status_byte, sample_code, read_index
//  out_o   | out | valid/ready   | channel_id .. read_error_count
//  cfg     | in  | cfg_we_i only | cfg_idx_i, cfg_data_i
//
//  One transfer per cycle sustained while the output is ready. The slot
//  memories are read on the input transfer, the frame stage modifies and
//  writes back, and the result lands in the output register.
//  A write in the frame stage that hits the slot being read the same cycle
//  is forwarded from the slot store's last-write register.
//  Reset clears valid bits, frame count and written bits and loads the
//  limits with their reset values at once; there is no clearing pass. A
//  stalled output holds the frame stage, which holds the input.
// ----------------------------------------------------------------------------
module adc_channel_sweep_capture_top
  import adcs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  adcs_in_if.sink                  in_i,
  adcs_out_if.source               out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic signed [CodeW-1:0] lo_lim_q, hi_lim_q;
  logic [CountW-1:0]       err_thr_q, late_lim_q, max_frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_lim_q     <= LowLimitRst;
      hi_lim_q     <= HighLimitRst;
      err_thr_q    <= ErrThrRst;
      late_lim_q   <= LateLimRst;
      max_frames_q <= MaxFramesRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgLowLimit:  lo_lim_q     <= cfg_data_i[CodeW-1:0];
        CfgHighLimit: hi_lim_q     <= cfg_data_i[CodeW-1:0];
        CfgErrThr:    err_thr_q    <= cfg_data_i[CountW-1:0];
        CfgLateLimit: late_lim_q   <= cfg_data_i[CountW-1:0];
        CfgMaxFrames: max_frames_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: frame stage advances into a free or draining output
  logic s1_vld_q, out_vld_q;
  logic s1_adv, in_xfer;

  assign s1_adv    = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_xfer   = in_i.valid && in_i.ready;

  // Read address: channel slot for a frame, read index for a read-back
  logic [ChW-1:0]   in_ch;
  logic [ChW-1:0]   in_slot_full;
  slot_rd_req_t     rd_req;
  slot_wr_req_t     wr_req;
  slot_rd_rsp_t     rd_rsp;

  assign in_ch        = in_i.status_byte[ChW-1:0];
  assign in_slot_full = in_ch - ChStart[ChW-1:0];

  always_comb begin
    rd_req.en = in_xfer;
    if (in_i.opcode == OpReadBack) begin
      rd_req.addr = in_i.read_index[SlotW-1:0];
    end else begin
      rd_req.addr = in_slot_full[SlotW-1:0];
    end
  end

  adcs_slot_store u_slot_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_req_i (rd_req),
    .wr_req_i (wr_req),
    .rd_rsp_o (rd_rsp)
  );

  // Frame stage registers
  logic              s1_op_q;
  logic [ChW-1:0]    s1_ch_q;
  logic [CodeW-1:0]  s1_code_q;
  logic [3:0]        s1_ridx_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q   <= in_i.opcode;
      s1_ch_q   <= in_ch;
      s1_code_q <= in_i.sample_code;
      s1_ridx_q <= in_i.read_index;
    end
  end

  // Sweep state
  logic [NumCh-1:0]  vmask_q;
  logic [CountW-1:0] frames_q;

  // Frame evaluation
  logic                    is_frame, known, inr, flag, done, fail, rd_oob;
  logic [ChW-1:0]          slot_full;
  logic [SlotW-1:0]        slot;
  logic signed [CodeW-1:0] code_s;
  logic [CountW-1:0]       err_new;
  logic [NumCh-1:0]        vmask_new;
  logic [CountW:0]         frames_inc;

  assign is_frame  = (s1_op_q == OpFrame);
  assign known     = ({1'b0, s1_ch_q} >= ChStart) && ({1'b0, s1_ch_q} < ChEnd);
  assign slot_full = s1_ch_q - ChStart[ChW-1:0];
  assign slot      = slot_full[SlotW-1:0];
  assign code_s    = s1_code_q;
  assign inr       = known && (code_s >= lo_lim_q) && (code_s <= hi_lim_q);
  assign err_new   = (rd_rsp.count == CountMax) ? CountMax : rd_rsp.count + 1'b1;
  assign flag      = known && !inr && (err_new >= err_thr_q);
  assign vmask_new = vmask_q | (inr ? (NumCh'(1) << slot) : '0);
  assign frames_inc = {1'b0, frames_q} + 1'b1;
  assign rd_oob    = ({1'b0, s1_ridx_q} >= NumChW);

  always_comb begin
    done = 1'b0;
    fail = 1'b0;
    if (vmask_new == {NumCh{1'b1}}) begin
      done = 1'b1;
      fail = (frames_q >= late_lim_q) || flag;
    end else if (frames_inc >= {1'b0, max_frames_q}) begin
      done = 1'b1;
      fail = 1'b1;
    end
  end

  // Write back on frame advance: store an in-range code, bump an error count
  always_comb begin
    wr_req.store_we   = s1_adv && is_frame && inr;
    wr_req.err_we     = s1_adv && is_frame && known && !inr;
    wr_req.addr       = slot;
    wr_req.store_data = s1_code_q;
    wr_req.err_data   = err_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      vmask_q  <= '0;
      frames_q <= '0;
    end else begin
      if (in_xfer) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv && is_frame) begin
        if (done) begin
          vmask_q  <= '0;
          frames_q <= '0;
        end else begin
          vmask_q  <= vmask_new;
          frames_q <= frames_inc[CountW-1:0];
        end
      end
    end
  end

  // Output register
  logic [ChW-1:0]          o_ch_q;
  logic                    o_known_q, o_inr_q, o_flag_q, o_done_q, o_fail_q;
  logic [NumCh-1:0]        o_mask_q;
  logic [CodeW-1:0]        o_val_q;
  logic [CountW-1:0]       o_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (is_frame) begin
        o_ch_q    <= s1_ch_q;
        o_known_q <= known;
        o_inr_q   <= inr;
        o_flag_q  <= flag;
        o_done_q  <= done;
        o_fail_q  <= fail;
        o_mask_q  <= vmask_new;
        o_val_q   <= '0;
        o_cnt_q   <= '0;
      end else begin
        o_ch_q    <= '0;
        o_known_q <= 1'b0;
        o_inr_q   <= 1'b0;
        o_flag_q  <= 1'b0;
        o_done_q  <= 1'b0;
        o_fail_q  <= 1'b0;
        o_mask_q  <= vmask_q;
        o_val_q   <= rd_oob ? '0 : rd_rsp.value;
        o_cnt_q   <= rd_oob ? '0 : rd_rsp.count;
      end
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.channel_id       = o_ch_q;
  assign out_o.channel_known    = o_known_q;
  assign out_o.in_range         = o_inr_q;
  assign out_o.error_flag       = o_flag_q;
  assign out_o.sweep_done       = o_done_q;
  assign out_o.sweep_fail       = o_fail_q;
  assign out_o.valid_mask       = o_mask_q;
  assign out_o.read_value       = o_val_q;
  assign out_o.read_error_count = o_cnt_q;

  // A finished sweep leaves mask and frame count cleared
  a_sweep_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && is_frame && done |=> vmask_q == '0 && frames_q == '0)
    else $error("sweep end did not clear mask and frame count");

  // Fail and in-range results only come with their qualifying flags
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && o_fail_q |-> o_done_q)
    else $error("sweep_fail without sweep_done");

  a_inr_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (o_inr_q || o_flag_q) |-> o_known_q && !(o_inr_q && o_flag_q))
    else $error("in_range or error_flag on an unknown channel");

  // The frame stage never accepts a new item while it is blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && out_vld_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while frame stage blocked");

endmodule
`default_nettype wire

>>> tb/adcs_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcs_tb_pkg
// Capture result type and scoreboard for the ADC channel sweep capture bench.
// ----------------------------------------------------------------------------
package adcs_tb_pkg;
  import adcs_pkg::*;

  typedef struct packed {
    logic [ChW-1:0]          channel_id;
    logic                    channel_known;
    logic                    in_range;
    logic                    error_flag;
    logic                    sweep_done;
    logic                    sweep_fail;
    logic [NumCh-1:0]        valid_mask;
    logic signed [CodeW-1:0] read_value;
    logic [CountW-1:0]       read_error_count;
  } capture_result_t;

  class capture_scoreboard;
    logic [CodeW-1:0]        slot_code [NumCh];
    logic [CountW-1:0]       slot_errs [NumCh];
    logic [NumCh-1:0]        valid_bits;
    logic [CountW-1:0]       frame_count;
    logic signed [CodeW-1:0] low_lim;
    logic signed [CodeW-1:0] high_lim;
    logic [CountW-1:0]       err_thr;
    logic [CountW-1:0]       late_lim;
    logic [CountW-1:0]       max_frames;
    capture_result_t         expected_captures [$];
    int unsigned             mismatches;

    function new();
      foreach (slot_code[i]) begin
        slot_code[i] = '0;
        slot_errs[i] = '0;
      end
      valid_bits  = '0;
      frame_count = '0;
      low_lim     = LowLimitRst;
      high_lim    = HighLimitRst;
      err_thr     = ErrThrRst;
      late_lim    = LateLimRst;
      max_frames  = MaxFramesRst;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgLowLimit:  low_lim    = data;
        CfgHighLimit: high_lim   = data;
        CfgErrThr:    err_thr    = data[CountW-1:0];
        CfgLateLimit: late_lim   = data[CountW-1:0];
        CfgMaxFrames: max_frames = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    // Work out the capture result of one accepted request and queue it
    function void note_request(opcode_e op, logic [7:0] status, logic [CodeW-1:0] code,
                               logic [3:0] ridx);
      capture_result_t r;
      logic [ChW-1:0]  ch;
      int              slot;
      r = '0;
      if (op == OpReadBack) begin
        r.valid_mask = valid_bits;
        if (ridx < NumCh) begin
          r.read_value       = slot_code[ridx];
          r.read_error_count = slot_errs[ridx];
        end
      end else begin
        ch           = status[ChW-1:0];
        r.channel_id = ch;
        if (ch >= FirstCh && ch < FirstCh + NumCh) begin
          slot            = ch - FirstCh;
          r.channel_known = 1'b1;
          if ($signed(code) >= low_lim && $signed(code) <= high_lim) begin
            r.in_range       = 1'b1;
            slot_code[slot]  = code;
            valid_bits[slot] = 1'b1;
          end else begin
            if (slot_errs[slot] != CountMax) slot_errs[slot] = slot_errs[slot] + 1'b1;
            r.error_flag = (slot_errs[slot] >= err_thr);
          end
        end
        r.valid_mask = valid_bits;
        if (&valid_bits) begin
          r.sweep_done = 1'b1;
          r.sweep_fail = (frame_count >= late_lim) || r.error_flag;
        end else if (int'(frame_count) + 1 >= int'(max_frames)) begin
          r.sweep_done = 1'b1;
          r.sweep_fail = 1'b1;
        end
        if (r.sweep_done) begin
          valid_bits  = '0;
          frame_count = '0;
        end else begin
          frame_count = frame_count + 1'b1;
        end
      end
      expected_captures.push_back(r);
    endfunction

    function string show(capture_result_t r);
      return $sformatf("ch=%0d known=%0b inr=%0b flag=%0b done=%0b fail=%0b mask=%03h val=%06h cnt=%0d",
                       r.channel_id, r.channel_known, r.in_range, r.error_flag, r.sweep_done,
                       r.sweep_fail, r.valid_mask, r.read_value, r.read_error_count);
    endfunction

    function void check_capture(capture_result_t got);
      capture_result_t want;
      string           bad;
      if (expected_captures.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("capture result with none expected: %s", show(got));
        return;
      end
      want = expected_captures.pop_front();
      bad  = "";
      if (got.channel_id !== want.channel_id)             bad = {bad, " channel_id"};
      if (got.channel_known !== want.channel_known)       bad = {bad, " channel_known"};
      if (got.in_range !== want.in_range)                 bad = {bad, " in_range"};
      if (got.error_flag !== want.error_flag)             bad = {bad, " error_flag"};
      if (got.sweep_done !== want.sweep_done)             bad = {bad, " sweep_done"};
      if (got.sweep_fail !== want.sweep_fail)             bad = {bad, " sweep_fail"};
      if (got.valid_mask !== want.valid_mask)             bad = {bad, " valid_mask"};
      if (got.read_value !== want.read_value)             bad = {bad, " read_value"};
      if (got.read_error_count !== want.read_error_count) bad = {bad, " read_error_count"};
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("capture mismatch in%s", bad);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return expected_captures.size();
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADC channel sweep capture block: directed edge
// cases, then randomized sweeps under several settings and flow-control mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import adcs_pkg::*;
  import adcs_tb_pkg::*;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  localparam int WatchdogLimit = 2000;
  localparam int NumPhases     = 7;
  localparam int SatPhase      = 4;
  localparam int ItemsPerPhase = 225;
  localparam int SatItems      = 400;
  localparam int HoldOffCycles = 60;
  localparam int HoldOffAt     = 100;
  localparam int PauseAt       = 180;

  localparam logic signed [CodeW-1:0] CodeMin = 24'sh800000;
  localparam logic signed [CodeW-1:0] CodeMax = 24'sh7FFFFF;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  adcs_in_if  in_ch ();
  adcs_out_if out_ch ();

  capture_scoreboard sb = new();

  // Flow-control knobs, shared by the sender tasks and the receiver process, and the watchdog's quiet count
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off       = 0;
  int quiet_cycles   = 0;

  // Current limits, mirrored here so stimulus can aim inside or outside them
  logic signed [CodeW-1:0] cur_lo = CodeMin;
  logic signed [CodeW-1:0] cur_hi = CodeMax;
  // Channels still missing from the sweep the stimulus is building
  logic [NumCh-1:0]        sweep_todo = '0;

  always #5 clk = ~clk;

  adc_channel_sweep_capture_top u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the clock edge. Every request transfer
  // queues one expected capture; every result transfer is checked against the
  // oldest one. Inputs change only through nonblocking updates, so the values
  // seen here are the ones the block sampled at this same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_request(opcode_e'(in_ch.opcode), in_ch.status_byte, in_ch.sample_code,
                        in_ch.read_index);
      if (out_ch.valid && out_ch.ready)
        sb.check_capture(capture_result_t'{
          channel_id:       out_ch.channel_id,
          channel_known:    out_ch.channel_known,
          in_range:         out_ch.in_range,
          error_flag:       out_ch.error_flag,
          sweep_done:       out_ch.sweep_done,
          sweep_fail:       out_ch.sweep_fail,
          valid_mask:       out_ch.valid_mask,
          read_value:       out_ch.read_value,
          read_error_count: out_ch.read_error_count});
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall at random, or hold ready low for a counted stretch when
  // the main sequence asks for back-pressure.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IdleNone:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IdleSender:   begin send_idle_pct = 54; recv_stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      IdleBoth:     begin send_idle_pct = 34; recv_stall_pct = 34; end
      default: ;
    endcase
  endtask

  // Offer one request, with random gaps ahead of it, and hold it until the
  // transfer. Valid stays high on return so back-to-back requests need no
  // extra edge; whoever stops sending drops it.
  task automatic send_item(opcode_e op, logic [7:0] status, logic [CodeW-1:0] code,
                           logic [3:0] ridx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.status_byte <= status;
    in_ch.sample_code <= code;
    in_ch.read_index  <= ridx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait until every expected capture has arrived. The first
  // edge lets the monitor log a transfer that happened on the return edge.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Write every register; call only with the block idle
  task automatic program_regs(logic signed [CodeW-1:0] lo, logic signed [CodeW-1:0] hi,
                              logic [CountW-1:0] thr, logic [CountW-1:0] late,
                              logic [CountW-1:0] maxf);
    write_reg(CfgLowLimit, lo);
    write_reg(CfgHighLimit, hi);
    write_reg(CfgErrThr, CfgDataW'(thr));
    write_reg(CfgLateLimit, CfgDataW'(late));
    write_reg(CfgMaxFrames, CfgDataW'(maxf));
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Pick a code inside the current limits (edges included), or one just outside or random
  function automatic logic [CodeW-1:0] pick_code(bit want_in);
    longint lo_v;
    longint hi_v;
    lo_v = cur_lo;
    hi_v = cur_hi;
    if (want_in && lo_v <= hi_v) begin
      case ($urandom_range(9))
        0:       return CodeW'(lo_v);
        1:       return CodeW'(hi_v);
        default: return CodeW'(lo_v + longint'($urandom) % (hi_v - lo_v + 1));
      endcase
    end
    case ($urandom_range(3))
      0:       return CodeW'(lo_v - 1);
      1:       return CodeW'(hi_v + 1);
      default: return CodeW'($urandom);
    endcase
  endfunction

  // One random request. Most are frames that walk the captured channels in a
  // random order so sweeps complete; the rest are read-backs, ignored
  // channels and raw noise. The saturation phase hammers mostly one slot instead.
  task automatic gen_item(int phase);
    int             kind;
    int             slot;
    logic [ChW-1:0] ch;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_item(OpReadBack, 8'($urandom), CodeW'($urandom), 4'($urandom_range(15)));
    end else if (kind < 16) begin
      ch = $urandom_range(19);
      if (ch >= FirstCh) ch = ch + NumCh;
      send_item(OpFrame, {3'($urandom), ch}, CodeW'($urandom), 4'($urandom));
    end else if (kind < 22) begin
      send_item(OpFrame, 8'($urandom), CodeW'($urandom), 4'($urandom));
    end else if (phase == SatPhase) begin
      slot = ($urandom_range(9) == 0) ? 1 : 0;
      send_item(OpFrame, {3'($urandom), ChW'(FirstCh + slot)},
                pick_code($urandom_range(99) < 5), 4'($urandom));
    end else begin
      if (sweep_todo == '0) sweep_todo = '1;
      do slot = $urandom_range(NumCh - 1); while (!sweep_todo[slot]);
      sweep_todo[slot] = 1'b0;
      send_item(OpFrame, {3'($urandom), ChW'(FirstCh + slot)},
                pick_code($urandom_range(99) < 85), 4'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [CodeW-1:0] lo_s;
    logic signed [CodeW-1:0] hi_s;
    int                      n_items;
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OpFrame;
    in_ch.status_byte <= '0;
    in_ch.sample_code <= '0;
    in_ch.read_index  <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CfgLowLimit;
    cfg_data          <= '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-range limits: read back untouched slots, including indexes past
    // the last slot, then the code extremes, ignored channels on both sides
    // of the window, and a sweep that completes early enough to pass.
    program_regs(CodeMin, CodeMax, ErrThrRst, LateLimRst, MaxFramesRst);
    send_item(OpReadBack, 8'h00, '0, 4'd0);
    send_item(OpReadBack, 8'hFF, 24'hFFFFFF, 4'd15);
    send_item(OpFrame, 8'h08, 24'h800000, 4'd0);
    send_item(OpFrame, 8'hF3, 24'h7FFFFF, 4'hF);
    send_item(OpFrame, 8'h07, 24'h000001, 4'd0);
    send_item(OpFrame, 8'h14, 24'h123456, 4'd0);
    send_item(OpFrame, 8'hFF, 24'hFEDCBA, 4'd0);
    for (int c = 1; c < NumCh - 1; c++)
      send_item(OpFrame, 8'(FirstCh + c), CodeW'($urandom), 4'd0);
    send_item(OpReadBack, 8'h00, '0, 4'd0);
    send_item(OpReadBack, 8'h00, '0, 4'd11);
    drain();

    // Narrow window: both edges land in range, one past each edge flags at a
    // threshold of one, and the frame limit closes the sweep as failed.
    program_regs(-24'sd100, 24'sd100, 8'd1, 8'd1, 8'd3);
    send_item(OpFrame, 8'h08, 24'd100, 4'd0);
    send_item(OpFrame, 8'h09, 24'hFFFF9C, 4'd0);
    send_item(OpFrame, 8'h0A, 24'd101, 4'd0);
    send_item(OpFrame, 8'h0B, 24'hFFFF9B, 4'd0);
    send_item(OpReadBack, 8'h00, '0, 4'd2);
    drain();

    // Empty window: low above high, nothing is in range
    program_regs(24'sd5, -24'sd5, 8'd255, 8'd255, 8'd255);
    send_item(OpFrame, 8'h0C, 24'd0, 4'd0);
    send_item(OpReadBack, 8'h00, '0, 4'd4);
    drain();

    // Random phases, each with its own register setting and idling mix
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          program_regs(CodeMin, CodeMax, 8'd255, 8'd255, 8'd255);
          set_idle(IdleNone);
        end
        1: begin
          lo_s = -CodeW'($urandom_range(4000000));
          hi_s = CodeW'($urandom_range(4000000));
          program_regs(lo_s, hi_s, 8'($urandom_range(2, 10)), 8'($urandom_range(10, 40)),
                       8'($urandom_range(12, 60)));
          set_idle(IdleSender);
        end
        2: begin
          hi_s = CodeW'($urandom);
          lo_s = hi_s - CodeW'($urandom_range(1000));
          program_regs(lo_s, hi_s, 8'd1, 8'd1, 8'd1);
          set_idle(IdleReceiver);
        end
        3: begin
          lo_s = CodeW'($urandom_range(1000, 100000));
          program_regs(lo_s, -lo_s, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)));
          set_idle(IdleBoth);
        end
        SatPhase: begin
          // Drive one slot's error count into saturation
          program_regs(-24'sd500, 24'sd500, 8'd255, 8'd20, 8'd200);
          set_idle(IdleNone);
        end
        5: begin
          program_regs(CodeMin, CodeMin + CodeW'($urandom_range(5000)), 8'd3,
                       8'($urandom_range(12, 30)), 8'd255);
          set_idle(IdleReceiver);
        end
        default: begin
          program_regs(CodeMax - CodeW'($urandom_range(5000)), CodeMax, 8'd2, 8'd12,
                       8'($urandom_range(13, 40)));
          set_idle(IdleSender);
        end
      endcase
      n_items = (p == SatPhase) ? SatItems : ItemsPerPhase;
      for (int n = 0; n < n_items; n++) begin
        // Hold off the receiver while requests keep coming so the block
        // fills and stalls its input; later pause the sender until empty.
        if (n == HoldOffAt) hold_off = HoldOffCycles;
        if (n == PauseAt) drain();
        gen_item(p);
      end
      drain();
    end

    // Let any stray capture show up before the verdict
    repeat (10) @(posedge clk);
    if (sb.mismatches + sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
